// File: src/lru_key_value_cache_assert.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared concurrent check helpers for the cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LKV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lru cache check failed");

// next-cycle implication, disabled while in reset
`define LKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lru cache check failed");

`endif

// File: src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared widths, reset values and cell control type of the lru cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int CapW     = 5;
  localparam int KeyW     = 32;
  localparam int ValW     = 31;
  localparam int OutW     = 32;
  localparam int DefSlots = 16;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // per-cell control
  typedef struct packed {
    logic cmp;    // capture key match
    logic shift;  // take entry from the neighbor
  } lkv_ctl_t;

endpackage

// File: src/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// valid/ready channels of the lru cache: request, response, capacity write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lkv_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [lkv_pkg::KeyW-1:0]  key;
  logic [lkv_pkg::ValW-1:0]  value;

  modport source (output valid, func, key, value, input ready);
  modport sink (input valid, func, key, value, output ready);
endinterface

interface lkv_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic signed [lkv_pkg::OutW-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink (input valid, found, read_value, output ready);
endinterface

interface lkv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::CapW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// a request is accepted in idle, compared in all cells, then applied by the update step (shift)
// no new request is accepted until the update step completes
// a get result waiting in a full output register holds the update step
// reset: store empty, capacity 16, no response pending; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
  parameter int SLOTS = lkv_pkg::DefSlots
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lkv_req_if.sink   req_i,
  lkv_rsp_if.source rsp_o,
  lkv_cfg_if.sink   cfg_i
);

  // slot position in the chain is its recency rank, 0 most recent;
  // valid slots always form a prefix of the chain
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int CmpW = (CntW > lkv_pkg::CapW) ? CntW : lkv_pkg::CapW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;

  // captured request
  logic                     req_func_q;
  logic [lkv_pkg::KeyW-1:0] req_key_q;
  logic [lkv_pkg::ValW-1:0] req_value_q;

  // capacity register and occupancy counter
  logic [lkv_pkg::CapW-1:0] cap_q;
  logic [CntW-1:0]          occ_q, occ_d;
  logic [CmpW-1:0]          eff_cap;
  logic                     full;

  // response register
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q;
  logic [lkv_pkg::ValW-1:0] out_value_q;

  // chain wiring
  logic [SLOTS-1:0]         cell_valid;
  logic [SLOTS-1:0]         cell_match;
  logic [lkv_pkg::KeyW-1:0] cell_key   [SLOTS];
  logic [lkv_pkg::ValW-1:0] cell_value [SLOTS];
  lkv_pkg::lkv_ctl_t        cell_ctl   [SLOTS];

  logic                     hit;
  logic [IdxW-1:0]          hit_idx;
  logic [lkv_pkg::ValW-1:0] hit_value;
  logic [lkv_pkg::ValW-1:0] head_value;

  logic                     upd_go;      // update step may complete
  logic                     upd_en;      // chain changes this step
  logic [CntW-1:0]          shift_lim;   // cells 0..shift_lim take their neighbor

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_found_q ? {1'b0, out_value_q} : '1;

  // get results wait for a free output register; sets never do
  assign upd_go = (state_q == S_UPD) && (req_func_q || !out_valid_q || rsp_o.ready);

  // --------------------------------------------------------------------------
  // sequencer: accept, compare, update
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_i.valid) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_func_q  <= req_i.func;
      req_key_q   <= req_i.key;
      req_value_q <= req_i.value;
    end
  end

  // --------------------------------------------------------------------------
  // capacity, clamped to 1..SLOTS
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CapReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cap_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(SLOTS)) begin
      eff_cap = CmpW'(SLOTS);
    end else begin
      eff_cap = CmpW'(cap_q);
    end
  end

  assign full = (CmpW'(occ_q) >= eff_cap);

  // --------------------------------------------------------------------------
  // hit select over the match row
  // --------------------------------------------------------------------------
  lkv_hit_sel #(
    .Slots (SLOTS),
    .IdxW  (IdxW)
  ) u_hit_sel (
    .match_i (cell_match),
    .value_i (cell_value),
    .found_o (hit),
    .idx_o   (hit_idx),
    .value_o (hit_value)
  );

  // --------------------------------------------------------------------------
  // chain update
  // hit (get or set): move hit entry to the head (a set writes its new value), ranks above it age by one
  // new key, not full: all valid entries move down one, chain grows by one
  // new key, full: the last valid entry (least recent) falls off the end
  // get miss: nothing changes
  // --------------------------------------------------------------------------
  assign upd_en     = upd_go && (hit || req_func_q);
  assign head_value = req_func_q ? req_value_q : hit_value;

  always_comb begin
    if (hit) begin
      shift_lim = CntW'(hit_idx);
    end else if (full) begin
      shift_lim = occ_q - 1'b1;
    end else begin
      shift_lim = occ_q;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (upd_go && req_func_q && !hit && !full) begin
      occ_d = occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic                     prev_valid;
    logic [lkv_pkg::KeyW-1:0] prev_key;
    logic [lkv_pkg::ValW-1:0] prev_value;

    if (g == 0) begin : g_head
      // head cell is fed by the entry being made most recent
      assign prev_valid = 1'b1;
      assign prev_key   = req_key_q;
      assign prev_value = head_value;
    end else begin : g_body
      assign prev_valid = cell_valid[g-1];
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
    end

    assign cell_ctl[g].cmp   = (state_q == S_CMP);
    assign cell_ctl[g].shift = upd_en && (CntW'(g) <= shift_lim);

    lkv_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[g]),
      .req_key_i    (req_key_q),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .valid_o      (cell_valid[g]),
      .key_o        (cell_key[g]),
      .value_o      (cell_value[g]),
      .match_o      (cell_match[g])
    );
  end

  // --------------------------------------------------------------------------
  // response register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (upd_go && !req_func_q) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go && !req_func_q) begin
      out_found_q <= hit;
      out_value_q <= hit_value;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // valid cells and the occupancy counter agree
  `LKV_ASSERT_NOW(a_occ_count, clk_i, rst_ni, 1'b1, $countones(cell_valid) == occ_q)
  // a key lives in at most one valid cell
  `LKV_ASSERT_NOW(a_match_unique, clk_i, rst_ni, state_q == S_UPD, $onehot0(cell_match))
  // occupancy never passes the slot count
  `LKV_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, CmpW'(occ_q) <= CmpW'(SLOTS))
  // a completed get always leaves a response behind
  `LKV_ASSERT_NEXT(a_get_resp, clk_i, rst_ni, upd_go && !req_func_q, out_valid_q)

endmodule

// File: src/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// one slot of the recency-ordered chain: valid, key, value and key match
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkv_pkg::lkv_ctl_t         ctl_i,
  input  logic [lkv_pkg::KeyW-1:0]  req_key_i,
  input  logic                      prev_valid_i,
  input  logic [lkv_pkg::KeyW-1:0]  prev_key_i,
  input  logic [lkv_pkg::ValW-1:0]  prev_value_i,
  output logic                      valid_o,
  output logic [lkv_pkg::KeyW-1:0]  key_o,
  output logic [lkv_pkg::ValW-1:0]  value_o,
  output logic                      match_o
);

  logic                     valid_q, valid_d;
  logic                     match_q, match_d;
  logic [lkv_pkg::KeyW-1:0] key_q;
  logic [lkv_pkg::ValW-1:0] value_q;

  always_comb begin
    valid_d = ctl_i.shift ? prev_valid_i : valid_q;
    match_d = ctl_i.cmp ? (valid_q && (key_q == req_key_i)) : match_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// File: src/lkv_hit_sel.sv
// ----------------------------------------------------------------------------
// lkv_hit_sel
// turns the one-hot match row into hit flag, hit position and hit value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_hit_sel #(
  parameter int Slots = lkv_pkg::DefSlots,
  parameter int IdxW  = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic [Slots-1:0]          match_i,
  input  logic [lkv_pkg::ValW-1:0]  value_i [Slots],
  output logic                      found_o,
  output logic [IdxW-1:0]           idx_o,
  output logic [lkv_pkg::ValW-1:0]  value_o
);

  // keys are unique among valid slots, so at most one match: and-or select
  always_comb begin
    idx_o   = '0;
    value_o = '0;
    for (int i = 0; i < Slots; i++) begin
      if (match_i[i]) begin
        idx_o   = idx_o | IdxW'(i);
        value_o = value_o | value_i[i];
      end
    end
  end

  assign found_o = |match_i;

endmodule
